@@ rtl/cal_pkg.sv @@
// Calendar clock package: word types, opcodes, calendar tables and the
// command and status structs between controller and datapath.
// No dependencies.
package cal_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [13:0] YEAR_MIN   = 14'd1;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;
  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MON_LAST   = 4'd11;
  localparam logic [3:0]  MON_MAR    = 4'd2;

  // y / 100 as (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // v / 7 as (v * DIV7_MUL) >> DIV7_SHIFT, exact for 9-bit v
  localparam logic [8:0]  DIV7_MUL     = 9'd293;
  localparam int          DIV7_SHIFT   = 11;
  // multiple of 7 that keeps the weekday sum positive
  localparam logic [9:0]  WDAY_BIAS    = 10'd203;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] in_year;
    logic [8:0]  in_day_of_year;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [3:0]  in_month;
    logic [4:0]  in_day_of_month;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [8:0]  cur_day_of_year;
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day_of_month;
    logic [2:0]  weekday;
    logic        accepted;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic div_cyear;
    logic div_mul;
    logic div_fix;
    logic exec;
    logic walk_init;
    logic walk_step;
    logic wk_sum;
    logic wk_mul;
    logic wk_mod;
    logic out_load;
  } cal_cmd_t;

  typedef struct packed {
    logic walk_done;
  } cal_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // (26 * m - 2) / 10 with m counted from March, indexed by zero-based month
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] o;
    case (m)
      4'd0:    o = 5'd28;
      4'd1:    o = 5'd31;
      4'd2:    o = 5'd2;
      4'd3:    o = 5'd5;
      4'd4:    o = 5'd7;
      4'd5:    o = 5'd10;
      4'd6:    o = 5'd12;
      4'd7:    o = 5'd15;
      4'd8:    o = 5'd18;
      4'd9:    o = 5'd20;
      4'd10:   o = 5'd23;
      4'd11:   o = 5'd25;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

@@ rtl/cal_ctrl.sv @@
// Calendar clock controller: sequences division, update, month walk and
// weekday steps, and owns the handshake flags.
// Depends on cal_pkg.
module cal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cal_pkg::cal_stat_t stat,
  output cal_pkg::cal_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_MUL,
    S_DIV_FIX,
    S_EXEC,
    S_WINIT,
    S_WALK,
    S_CDIV_MUL,
    S_CDIV_FIX,
    S_WK_SUM,
    S_WK_MUL,
    S_WK_MOD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;

  assign load      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.div_mul   = (state_r == S_DIV_MUL) || (state_r == S_CDIV_MUL);
    cmd.div_cyear = (state_r == S_CDIV_MUL);
    cmd.div_fix   = (state_r == S_DIV_FIX) || (state_r == S_CDIV_FIX);
    cmd.exec      = (state_r == S_EXEC);
    cmd.walk_init = (state_r == S_WINIT);
    cmd.walk_step = (state_r == S_WALK) && !stat.walk_done;
    cmd.wk_sum    = (state_r == S_WK_SUM);
    cmd.wk_mul    = (state_r == S_WK_MUL);
    cmd.wk_mod    = (state_r == S_WK_MOD);
    cmd.out_load  = load;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DIV_MUL;
      S_DIV_MUL:  state_nxt = S_DIV_FIX;
      S_DIV_FIX:  state_nxt = S_EXEC;
      S_EXEC:     state_nxt = S_WINIT;
      S_WINIT:    state_nxt = S_WALK;
      S_WALK:     if (stat.walk_done) state_nxt = S_CDIV_MUL;
      S_CDIV_MUL: state_nxt = S_CDIV_FIX;
      S_CDIV_FIX: state_nxt = S_WK_SUM;
      S_WK_SUM:   state_nxt = S_WK_MUL;
      S_WK_MUL:   state_nxt = S_WK_MOD;
      S_WK_MOD:   state_nxt = S_DONE;
      S_DONE:     if (load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/cal_dp.sv @@
// Calendar clock datapath: time counters, shared divide-by-100 unit, month
// walk, weekday arithmetic and the result register.
// Depends on cal_pkg.
module cal_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cal_pkg::in_word_t   in_word,
  input  cal_pkg::cal_cmd_t   cmd,
  output cal_pkg::cal_stat_t  stat,
  output cal_pkg::out_word_t  out_word
);

  cal_pkg::in_word_t  req_r;
  cal_pkg::out_word_t res_r;

  logic [5:0]  sec_r, min_r;
  logic [4:0]  hour_r;
  logic [8:0]  day_r;
  logic [13:0] year_r;
  logic        leap_r, acc_r;

  logic [13:0] dy_r;
  logic [7:0]  dq_r;
  logic [6:0]  drem_r;
  logic [3:0]  wm_r;
  logic [8:0]  wd_r;
  logic [8:0]  wv_r;
  logic [6:0]  wq_r;
  logic [2:0]  wday_r;

  logic [13:0] div_src, cyear;
  logic [26:0] div_prod;
  logic [14:0] q100;
  logic        leap;
  logic [4:0]  walk_len;
  logic [9:0]  wk_pos;
  logic [9:0]  wk_val;
  logic [17:0] wk_prod;
  logic [9:0]  q7;
  logic        set_ok, load_ok;
  logic [8:0]  set_day;
  logic [8:0]  year_last;

  assign cyear    = year_r - {13'd0, (wm_r < cal_pkg::MON_MAR)};
  assign div_src  = cmd.div_cyear ? cyear :
                    (req_r.opcode == cal_pkg::OP_LOAD) ? req_r.in_year : year_r;
  assign div_prod = div_src * cal_pkg::DIV100_MUL;
  assign q100     = dq_r * 7'd100;
  assign leap     = (dy_r[1:0] == 2'd0) && ((drem_r != 7'd0) || (dq_r[1:0] == 2'd0));

  assign walk_len       = cal_pkg::month_len(wm_r, leap_r);
  assign stat.walk_done = (wm_r == cal_pkg::MON_LAST) || (wd_r < {4'd0, walk_len});

  assign wk_pos  = {5'd0, wd_r[4:0]} + 10'd1 + {5'd0, cal_pkg::month_offset(wm_r)}
                 + {3'd0, drem_r} + {5'd0, drem_r[6:2]} + {4'd0, dq_r[7:2]}
                 + cal_pkg::WDAY_BIAS;
  assign wk_val  = wk_pos - {1'b0, dq_r, 1'b0};
  assign wk_prod = wv_r * cal_pkg::DIV7_MUL;
  assign q7      = wq_r * 3'd7;

  assign year_last = leap ? 9'd365 : 9'd364;
  assign set_ok    = (req_r.in_month <= cal_pkg::MON_LAST) &&
                     (req_r.in_day_of_month < cal_pkg::month_len(req_r.in_month, leap));
  assign set_day   = cal_pkg::month_start(req_r.in_month)
                   + {8'd0, leap && (req_r.in_month >= cal_pkg::MON_MAR)}
                   + {4'd0, req_r.in_day_of_month};
  assign load_ok   = (req_r.in_year >= cal_pkg::YEAR_MIN) &&
                     (req_r.in_year <= cal_pkg::YEAR_MAX) &&
                     (req_r.in_day_of_year <= year_last) &&
                     (req_r.in_hour <= cal_pkg::HOUR_LAST) &&
                     (req_r.in_minute <= cal_pkg::MIN_LAST) &&
                     (req_r.in_second <= cal_pkg::SEC_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      day_r  <= '0;
      year_r <= cal_pkg::YEAR_RESET;
    end else if (cmd.exec) begin
      case (req_r.opcode)
        cal_pkg::OP_TICK: begin
          if (sec_r != cal_pkg::SEC_LAST) begin
            sec_r <= sec_r + 6'd1;
          end else begin
            sec_r <= '0;
            if (min_r != cal_pkg::MIN_LAST) begin
              min_r <= min_r + 6'd1;
            end else begin
              min_r <= '0;
              if (hour_r != cal_pkg::HOUR_LAST) begin
                hour_r <= hour_r + 5'd1;
              end else begin
                hour_r <= '0;
                if (day_r < year_last) begin
                  day_r <= day_r + 9'd1;
                end else begin
                  day_r  <= '0;
                  year_r <= (year_r >= cal_pkg::YEAR_MAX) ? cal_pkg::YEAR_MIN
                                                          : year_r + 14'd1;
                end
              end
            end
          end
        end
        cal_pkg::OP_SET: begin
          if (set_ok) day_r <= set_day;
        end
        cal_pkg::OP_LOAD: begin
          if (load_ok) begin
            year_r <= req_r.in_year;
            day_r  <= req_r.in_day_of_year;
            hour_r <= req_r.in_hour;
            min_r  <= req_r.in_minute;
            sec_r  <= req_r.in_second;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_word;
    if (cmd.div_mul) begin
      dy_r <= div_src;
      dq_r <= div_prod[26:cal_pkg::DIV100_SHIFT];
    end
    if (cmd.div_fix) drem_r <= dy_r[6:0] - q100[6:0];
    if (cmd.exec) begin
      // hold the current year's flag when a load is refused
      if ((req_r.opcode != cal_pkg::OP_LOAD) || load_ok) leap_r <= leap;
      case (req_r.opcode)
        cal_pkg::OP_TICK: acc_r <= 1'b1;
        cal_pkg::OP_SET:  acc_r <= set_ok;
        cal_pkg::OP_LOAD: acc_r <= load_ok;
        default:          acc_r <= 1'b0;
      endcase
    end
    if (cmd.walk_init) begin
      wm_r <= '0;
      wd_r <= day_r;
    end else if (cmd.walk_step) begin
      wm_r <= wm_r + 4'd1;
      wd_r <= wd_r - {4'd0, walk_len};
    end
    if (cmd.wk_sum) wv_r <= wk_val[8:0];
    if (cmd.wk_mul) wq_r <= wk_prod[17:cal_pkg::DIV7_SHIFT];
    if (cmd.wk_mod) wday_r <= wv_r[2:0] - q7[2:0];
    if (cmd.out_load) begin
      res_r.cur_second       <= sec_r;
      res_r.cur_minute       <= min_r;
      res_r.cur_hour         <= hour_r;
      res_r.cur_day_of_year  <= day_r;
      res_r.cur_year         <= year_r;
      res_r.cur_month        <= wm_r;
      res_r.cur_day_of_month <= wd_r[4:0];
      res_r.weekday          <= wday_r;
      res_r.accepted         <= acc_r;
    end
  end

  assign out_word = res_r;

endmodule

@@ rtl/calendar_clock_counter.sv @@
// Calendar clock top level: joins controller and datapath.
// Depends on cal_pkg, cal_ctrl and cal_dp.
//
// Input channel in_valid/in_stall/in_word carries one command word: tick
// one second, set month and day, or load the whole time. Output channel
// out_valid/out_stall/out_word returns one result word per command with
// the time after the command, month, day of month, weekday and an
// accepted flag (0 for a rejected set or load, or an unused opcode).
// One command is worked at a time. The month walk steps through the
// months one by one, and the next command can be taken in the cycle
// after the result is registered.
// The result sits in an output register; a stalled receiver holds it,
// and the next command may be taken and worked meanwhile, waiting at the
// end until the register frees up.
// Reset clears the time to 00:00:00 on day 0 of year 2000 and empties
// the output register.
module calendar_clock_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cal_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cal_pkg::out_word_t out_word
);

  cal_pkg::cal_cmd_t  cmd;
  cal_pkg::cal_stat_t stat;

  cal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cal_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

@@ sim/calendar_checker.sv @@
// Calendar clock checker: predicts the result word of every command word taken
// in and compares it field by field with the word the block returns.
// Depends on cal_pkg.
module calendar_checker
  import cal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        mismatches,
  output int        waiting,
  output int        compared
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [5:0]  cal_sec;
  logic [5:0]  cal_min;
  logic [4:0]  cal_hour;
  logic [8:0]  cal_day;
  logic [13:0] cal_year;

  out_word_t pending_readings[$];

  function automatic bit is_leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_in_year(input int y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  function automatic int days_in_month(input int m, input int y);
    int len;
    case (m)
      0, 2, 4, 6, 7, 9, 11: len = 31;
      3, 5, 8, 10:          len = 30;
      1:                    len = is_leap_year(y) ? 29 : 28;
      default:              len = 0;
    endcase
    return len;
  endfunction

  task automatic apply_command(input in_word_t cmd, output out_word_t rd);
    int  d;
    int  m;
    int  mon;
    int  cyear;
    int  shifted;
    int  yy;
    int  cc;
    int  x;
    int  wd;
    bit  acc;
    acc = 1'b0;
    case (cmd.opcode)
      OP_TICK: begin
        cal_sec = cal_sec + 6'd1;
        if (cal_sec >= 6'd60) begin
          cal_sec = '0;
          cal_min = cal_min + 6'd1;
        end
        if (cal_min >= 6'd60) begin
          cal_min  = '0;
          cal_hour = cal_hour + 5'd1;
        end
        if (cal_hour >= 5'd24) begin
          cal_hour = '0;
          cal_day  = cal_day + 9'd1;
        end
        if (int'(cal_day) >= days_in_year(int'(cal_year))) begin
          cal_day  = '0;
          cal_year = (cal_year >= YEAR_MAX) ? YEAR_MIN : cal_year + 14'd1;
        end
        acc = 1'b1;
      end
      OP_SET: begin
        if (cmd.in_month < 4'd12 &&
            int'(cmd.in_day_of_month) < days_in_month(int'(cmd.in_month), int'(cal_year))) begin
          d = 0;
          for (m = 0; m < int'(cmd.in_month); m++) d += days_in_month(m, int'(cal_year));
          cal_day = 9'(d + int'(cmd.in_day_of_month));
          acc = 1'b1;
        end
      end
      OP_LOAD: begin
        if (cmd.in_year >= YEAR_MIN && cmd.in_year <= YEAR_MAX &&
            int'(cmd.in_day_of_year) < days_in_year(int'(cmd.in_year)) &&
            cmd.in_hour < 5'd24 && cmd.in_minute < 6'd60 && cmd.in_second < 6'd60) begin
          cal_year = cmd.in_year;
          cal_day  = cmd.in_day_of_year;
          cal_hour = cmd.in_hour;
          cal_min  = cmd.in_minute;
          cal_sec  = cmd.in_second;
          acc = 1'b1;
        end
      end
      default: ;
    endcase

    d   = int'(cal_day);
    mon = 0;
    while (mon < 11 && d >= days_in_month(mon, int'(cal_year))) begin
      d -= days_in_month(mon, int'(cal_year));
      mon++;
    end

    cyear   = int'(cal_year) - ((mon < 2) ? 1 : 0);
    shifted = (mon + 10) % 12 + 1;
    yy      = cyear % 100;
    cc      = cyear / 100;
    x       = d + 1 + (26 * shifted - 2) / 10 + yy + yy / 4 + cc / 4 - 2 * cc;
    wd      = x % 7;
    if (wd < 0) wd += 7;

    rd.cur_second       = cal_sec;
    rd.cur_minute       = cal_min;
    rd.cur_hour         = cal_hour;
    rd.cur_day_of_year  = cal_day;
    rd.cur_year         = cal_year;
    rd.cur_month        = 4'(mon);
    rd.cur_day_of_month = 5'(d);
    rd.weekday          = 3'(wd);
    rd.accepted         = acc;
  endtask

  task automatic check_field(input string name, input logic [13:0] expv,
                             input logic [13:0] actv);
    if (actv !== expv) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_rd;
    out_word_t new_rd;
    if (!rst_n) begin
      cal_sec    <= '0;
      cal_min    <= '0;
      cal_hour   <= '0;
      cal_day    <= '0;
      cal_year   <= YEAR_RESET;
      mismatches <= 0;
      compared   <= 0;
      waiting    <= 0;
      pending_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t ns: result word expected none, got %h", $time, out_word);
        end else begin
          exp_rd = pending_readings.pop_front();
          compared++;
          check_field("cur_second", exp_rd.cur_second, out_word.cur_second);
          check_field("cur_minute", exp_rd.cur_minute, out_word.cur_minute);
          check_field("cur_hour", exp_rd.cur_hour, out_word.cur_hour);
          check_field("cur_day_of_year", exp_rd.cur_day_of_year, out_word.cur_day_of_year);
          check_field("cur_year", exp_rd.cur_year, out_word.cur_year);
          check_field("cur_month", exp_rd.cur_month, out_word.cur_month);
          check_field("cur_day_of_month", exp_rd.cur_day_of_month, out_word.cur_day_of_month);
          check_field("weekday", exp_rd.weekday, out_word.weekday);
          check_field("accepted", exp_rd.accepted, out_word.accepted);
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_word, new_rd);
        pending_readings.push_back(new_rd);
      end
      waiting <= pending_readings.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// Calendar clock testbench top: clock, reset, command words with random gaps,
// random result stalls and the final verdict.
// Depends on cal_pkg, calendar_clock_counter and calendar_checker.
module testbench;
  import cal_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_WORDS = 1150;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int mismatches;
  int waiting;
  int compared;
  int directed_count;
  bit in_quiet;
  bit out_quiet;

  in_word_t directed_words[$];

  calendar_clock_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  calendar_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .mismatches (mismatches),
    .waiting    (waiting),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", waiting);
    $display("testbench failed");
    $finish;
  end

  function automatic in_word_t make_cmd(input logic [1:0] op, input int y, input int doy,
                                        input int h, input int mi, input int s,
                                        input int mon, input int dom);
    in_word_t w;
    w.opcode          = op;
    w.in_year         = 14'(y);
    w.in_day_of_year  = 9'(doy);
    w.in_hour         = 5'(h);
    w.in_minute       = 6'(mi);
    w.in_second       = 6'(s);
    w.in_month        = 4'(mon);
    w.in_day_of_month = 5'(dom);
    return w;
  endfunction

  function automatic in_word_t random_cmd();
    in_word_t    w;
    logic [63:0] raw;
    int          pick;
    raw  = {$urandom(), $urandom()};
    w    = raw[$bits(in_word_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.opcode = OP_TICK;
    end else if (pick < 55) begin
      w.opcode = OP_LOAD;
      case ($urandom_range(0, 6))
        0: w.in_year = YEAR_MAX;
        1: w.in_year = YEAR_MIN;
        2: w.in_year = 14'd1900;
        3: w.in_year = 14'd2000;
        4: w.in_year = 14'd2100;
        5: w.in_year = 14'd2400;
        default: w.in_year = 14'($urandom_range(1, 9999));
      endcase
      w.in_day_of_year = 9'($urandom_range(363, 365));
      w.in_hour        = 5'($urandom_range(22, 23));
      w.in_minute      = 6'($urandom_range(58, 59));
      w.in_second      = 6'($urandom_range(57, 59));
    end else if (pick < 70) begin
      w.opcode          = OP_SET;
      w.in_month        = 4'($urandom_range(0, 11));
      w.in_day_of_month = 5'($urandom_range(0, 30));
    end else if (pick < 85) begin
      w.opcode         = OP_LOAD;
      w.in_year        = 14'($urandom_range(1, 9999));
      w.in_day_of_year = 9'($urandom_range(0, 365));
      w.in_hour        = 5'($urandom_range(0, 23));
      w.in_minute      = 6'($urandom_range(0, 59));
      w.in_second      = 6'($urandom_range(0, 59));
    end
    return w;
  endfunction

  task automatic send_cmd(input in_word_t cmd);
    int gap;
    if ($urandom_range(0, 49) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= cmd;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int gap;
    out_stall <= 1'b1;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    in_quiet  = 1'b0;
    out_quiet = 1'b0;

    directed_words.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 9999, 364, 23, 59, 59, 0, 0));
    directed_words.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 2000, 365, 23, 59, 59, 0, 0));
    directed_words.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 1900, 365, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 2400, 365, 12, 30, 30, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 0, 10, 1, 1, 1, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 10000, 10, 1, 1, 1, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 16383, 511, 31, 63, 63, 15, 31));
    directed_words.push_back(make_cmd(OP_LOAD, 2023, 100, 24, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 2023, 100, 0, 60, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 2023, 100, 0, 0, 60, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 2024, 59, 23, 59, 59, 0, 0));
    directed_words.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_SET, 0, 0, 0, 0, 0, 1, 28));
    directed_words.push_back(make_cmd(OP_LOAD, 2023, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_SET, 0, 0, 0, 0, 0, 1, 28));
    directed_words.push_back(make_cmd(OP_SET, 0, 0, 0, 0, 0, 11, 30));
    directed_words.push_back(make_cmd(OP_SET, 0, 0, 0, 0, 0, 12, 0));
    directed_words.push_back(make_cmd(OP_SET, 16383, 511, 31, 63, 63, 15, 31));
    directed_words.push_back(make_cmd(OP_SET, 0, 0, 0, 0, 0, 3, 30));
    directed_words.push_back(make_cmd(OP_SET, 0, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_UNUSED, 16383, 511, 31, 63, 63, 15, 31));
    directed_words.push_back(make_cmd(OP_LOAD, 1, 0, 0, 0, 0, 0, 0));
    directed_words.push_back(make_cmd(OP_LOAD, 2100, 364, 23, 59, 59, 0, 0));
    directed_words.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed_count = directed_words.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_cmd(directed_words[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) send_cmd(random_cmd());
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("sent %0d command words (%0d directed, %0d random), compared %0d results",
             directed_count + RANDOM_WORDS, directed_count, RANDOM_WORDS, compared);
    $display("covered ticks with day and year carries, month/day sets, loads and rejects");
    if (mismatches == 0 && waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cal_pkg.sv
rtl/cal_ctrl.sv
rtl/cal_dp.sv
rtl/calendar_clock_counter.sv
sim/calendar_checker.sv
sim/testbench.sv
